// ===== src/sphere_overlap_pushout_top_defines.svh =====
// Assertion macros for the sphere overlap pushout block.
// Used by the port checker; no other dependencies.
`ifndef SPHERE_OVERLAP_PUSHOUT_TOP_DEFINES_SVH
`define SPHERE_OVERLAP_PUSHOUT_TOP_DEFINES_SVH

// Clocked property, masked while reset is high.
`define SPO_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spo check failed");

// Clocked property, live during reset too.
`define SPO_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spo check failed");

`endif

// ===== src/spo_pkg.sv =====
// Types and constants for the sphere overlap pushout block.
// No dependencies.
package spo_pkg;

  localparam int NUM_AXES   = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic        [30:0] a_radius;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic        [30:0] b_radius;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } rsp_t;

  // Square-root chain stage contents.
  typedef struct packed {
    logic                            valid;
    logic                            hit;
    logic [NUM_AXES-1:0]             neg;
    logic [NUM_AXES-1:0][31:0]       mag;
    logic [31:0]                     r;
    logic [NUM_AXES-1:0][31:0]       base;
    logic [63:0]                     s;
    logic [34:0]                     rem;
    logic [31:0]                     root;
  } sqrt_t;

  // Divider chain stage contents.
  typedef struct packed {
    logic                            valid;
    logic                            hit;
    logic                            nz;
    logic [NUM_AXES-1:0]             neg;
    logic [NUM_AXES-1:0][31:0]       base;
    logic [31:0]                     len;
    logic [NUM_AXES-1:0][31:0]       rem;
    logic [NUM_AXES-1:0][31:0]       nq;
  } div_t;

endpackage

// ===== src/spo_front.sv =====
// Front end: per-axis differences, squares and the overlap compare.
// Depends on spo_pkg.
module spo_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          req_valid,
  input  spo_pkg::req_t req,
  output spo_pkg::sqrt_t dout
);
  import spo_pkg::*;

  logic [NUM_AXES-1:0][31:0] a_in, b_in;
  logic [NUM_AXES-1:0][32:0] d_in;

  logic                      v1;
  logic [NUM_AXES-1:0][31:0] a1, b1, mag1;
  logic [NUM_AXES-1:0]       neg1;
  logic [31:0]               r1;

  logic                      v2;
  logic [NUM_AXES-1:0][31:0] a2, b2, mag2;
  logic [NUM_AXES-1:0]       neg2;
  logic [31:0]               r2;
  logic [NUM_AXES-1:0][63:0] sq2;
  logic [63:0]               rsq2;

  logic [65:0]               s_sum;
  logic                      hit_c;

  // Axis 0 is x, axis 2 is z.
  assign a_in = {req.a_z, req.a_y, req.a_x};
  assign b_in = {req.b_z, req.b_y, req.b_x};

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      d_in[i] = {a_in[i][31], a_in[i]} - {b_in[i][31], b_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg1[i] <= d_in[i][32];
        mag1[i] <= d_in[i][32] ? 32'(-d_in[i]) : d_in[i][31:0];
        sq2[i]  <= 64'(mag1[i]) * 64'(mag1[i]);
      end
      a1   <= a_in;
      b1   <= b_in;
      r1   <= {1'b0, req.a_radius} + {1'b0, req.b_radius};
      a2   <= a1;
      b2   <= b1;
      mag2 <= mag1;
      neg2 <= neg1;
      r2   <= r1;
      rsq2 <= 64'(r1) * 64'(r1);
    end
  end

  assign s_sum = {2'b00, sq2[0]} + {2'b00, sq2[1]} + {2'b00, sq2[2]};
  assign hit_c = s_sum <= {2'b00, rsq2};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v2;
    end
    if (en) begin
      dout.hit  <= hit_c;
      dout.neg  <= neg2;
      dout.mag  <= mag2;
      dout.r    <= r2;
      dout.base <= hit_c ? b2 : a2;
      dout.s    <= s_sum[63:0];
      dout.rem  <= '0;
      dout.root <= '0;
    end
  end

endmodule

// ===== src/spo_sqrt_cell.sv =====
// One square-root cell: retires two radicand bits, one root bit.
// Depends on spo_pkg.
module spo_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  spo_pkg::sqrt_t din,
  output spo_pkg::sqrt_t dout
);
  import spo_pkg::*;

  logic [34:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {din.rem[32:0], din.s[63:62]};
  assign trial  = {1'b0, din.root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.hit  <= din.hit;
      dout.neg  <= din.neg;
      dout.mag  <= din.mag;
      dout.r    <= din.r;
      dout.base <= din.base;
      dout.s    <= {din.s[61:0], 2'b00};
      dout.rem  <= ge ? rem_sh - trial : rem_sh;
      dout.root <= {din.root[30:0], ge};
    end
  end

endmodule

// ===== src/spo_scale.sv =====
// Scaling stages: offset numerators |d| * R + len / 2 per axis.
// Depends on spo_pkg.
module spo_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  spo_pkg::sqrt_t din,
  output spo_pkg::div_t  dout
);
  import spo_pkg::*;

  logic                      v1, hit1;
  logic [NUM_AXES-1:0]       neg1;
  logic [NUM_AXES-1:0][31:0] base1;
  logic [31:0]               len1;
  logic [NUM_AXES-1:0][63:0] prod1;
  logic [NUM_AXES-1:0][64:0] num;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      num[i] = {1'b0, prod1[i]} + {34'd0, len1[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v1;
    end
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod1[i]    <= 64'(din.mag[i]) * 64'(din.r);
        dout.rem[i] <= num[i][63:32];
        dout.nq[i]  <= num[i][31:0];
      end
      hit1      <= din.hit;
      neg1      <= din.neg;
      base1     <= din.base;
      len1      <= din.root;
      dout.hit  <= hit1;
      dout.nz   <= len1 != '0;
      dout.neg  <= neg1;
      dout.base <= base1;
      dout.len  <= len1;
    end
  end

endmodule

// ===== src/spo_div_cell.sv =====
// One restoring-division cell: one quotient bit for each axis.
// Depends on spo_pkg.
module spo_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  spo_pkg::div_t din,
  output spo_pkg::div_t dout
);
  import spo_pkg::*;

  logic [NUM_AXES-1:0][32:0] rem_sh, diff;
  logic [NUM_AXES-1:0]       ge;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      rem_sh[i] = {din.rem[i], din.nq[i][31]};
      diff[i]   = rem_sh[i] - {1'b0, din.len};
      ge[i]     = rem_sh[i] >= {1'b0, din.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dout.rem[i] <= ge[i] ? diff[i][31:0] : rem_sh[i][31:0];
        dout.nq[i]  <= {din.nq[i][30:0], ge[i]};
      end
      dout.hit  <= din.hit;
      dout.nz   <= din.nz;
      dout.neg  <= din.neg;
      dout.base <= din.base;
      dout.len  <= din.len;
    end
  end

endmodule

// ===== src/sphere_overlap_pushout_top.sv =====
// Sphere overlap pushout, top level. Depends on spo_pkg and all spo_* modules.
// Stages from accepted request to result: 3 front, 32 root cells, 2 scale,
// 32 divider cells, 1 output register.
// Throughput: one transaction per cycle; the whole pipe advances together and
// holds only while a result sits in the output register under stall.
// Reset (rst, synchronous, active high) clears every valid bit; data needs none.
module sphere_overlap_pushout_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spo_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spo_pkg::rsp_t rsp
);
  import spo_pkg::*;

  // Advance the pipe unless a finished result is held by the consumer.
  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  sqrt_t sq_chain [0:SQRT_STEPS];
  div_t  dv_chain [0:DIV_STEPS];

  // Differences, squares, and the hit decision; pick B or A as the base.
  spo_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .req_valid(req_valid), .req(req),
    .dout(sq_chain[0])
  );

  // Integer square root of the squared distance, one root bit per cell.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    spo_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .din(sq_chain[k]), .dout(sq_chain[k+1])
    );
  end

  // Build the rounded numerators |d| * R + len / 2.
  spo_scale u_scale (
    .clk(clk), .rst(rst), .en(en),
    .din(sq_chain[SQRT_STEPS]), .dout(dv_chain[0])
  );

  // Divide by the distance, one quotient bit per cell on all three axes.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    spo_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .din(dv_chain[k]), .dout(dv_chain[k+1])
    );
  end

  // Apply the signed offset to the base and saturate to 32 bits.
  div_t                      last;
  logic [NUM_AXES-1:0][33:0] off, sum;
  logic [NUM_AXES-1:0][31:0] res;

  assign last = dv_chain[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      off[i] = '0;
      if (last.hit && last.nz) begin
        off[i] = last.neg[i] ? 34'(-{2'b00, last.nq[i]}) : {2'b00, last.nq[i]};
      end
      sum[i] = {{2{last.base[i][31]}}, last.base[i]} + off[i];
      if (!sum[i][33] && sum[i][32:31] != 2'b00) begin
        res[i] = 32'h7fff_ffff;
      end else if (sum[i][33] && sum[i][32:31] != 2'b11) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = sum[i][31:0];
      end
    end
  end

  // Output register: load on advance, hold under stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit   <= last.hit;
      rsp.out_x <= res[0];
      rsp.out_y <= res[1];
      rsp.out_z <= res[2];
    end
  end

endmodule

// ===== src/spo_check.sv =====
// Port-level checker for the sphere overlap pushout top level, with its bind.
// Depends on spo_pkg and sphere_overlap_pushout_top_defines.svh.
`include "sphere_overlap_pushout_top_defines.svh"

module spo_check (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input spo_pkg::rsp_t rsp
);
  import spo_pkg::*;

  // A held result holds its value.
  `SPO_ASSERT_RST(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
  // A held result backs up into the request side in the same cycle.
  `SPO_ASSERT_RST(a_back_press, clk, rst, rsp_valid && rsp_stall |-> req_stall)
  // Reset drops any result.
  `SPO_ASSERT(a_reset_empty, clk, $past(rst) |-> !rsp_valid)
  // With no result waiting, requests are never stalled.
  `SPO_ASSERT_RST(a_free_flow, clk, rst, !rsp_valid |-> !req_stall)

endmodule

bind sphere_overlap_pushout_top spo_check u_spo_check (
  .clk(clk), .rst(rst),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
  .rsp(rsp)
);

// ===== tb/sv/spo_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the sphere overlap pushout block: watches both channels,
// predicts each resolved center and compares. Depends on spo_pkg.
module spo_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  spo_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  spo_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            hits_seen,
  output int            results_seen
);
  import spo_pkg::*;

  rsp_t resolved_q[$];

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res, bitv, v;
    res = 0;
    v = n;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic rsp_t resolve_pair(input req_t p);
    rsp_t o;
    logic signed [32:0] a [3];
    logic signed [32:0] b [3];
    logic signed [32:0] d [3];
    logic [32:0] m [3];
    logic [66:0] sum;
    logic [63:0] rad, rsq, len, q;
    logic signed [65:0] off;
    a[0] = p.a_x; a[1] = p.a_y; a[2] = p.a_z;
    b[0] = p.b_x; b[1] = p.b_y; b[2] = p.b_z;
    rad = 64'(p.a_radius) + 64'(p.b_radius);
    rsq = rad * rad;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = a[i] - b[i];
      m[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sum = sum + 67'(m[i]) * 67'(m[i]);
    end
    // A sum past 64 bits can never be a hit.
    if (sum > 67'(rsq)) begin
      o.hit = 1'b0;
      o.out_x = p.a_x; o.out_y = p.a_y; o.out_z = p.a_z;
      return o;
    end
    len = floor_root(sum[63:0]);
    o.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      off = 0;
      if (len != 0) begin
        q = (64'(m[i]) * rad + (len >> 1)) / len;
        off = d[i] < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q});
      end
      case (i)
        0: o.out_x = clamp32(66'(b[i]) + off);
        1: o.out_y = clamp32(66'(b[i]) + off);
        default: o.out_z = clamp32(66'(b[i]) + off);
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = resolved_q.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      resolved_q.delete();
      fail_count = 0;
      hits_seen <= 0;
      results_seen <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen <= results_seen + 1;
        if (resolved_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(rsp.hit), 0);
        end else begin
          want = resolved_q.pop_front();
          if (rsp.hit) hits_seen <= hits_seen + 1;
          if (rsp.hit !== want.hit) report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
          if (rsp.out_x !== want.out_x) report_mismatch("out_x", rsp.out_x, want.out_x);
          if (rsp.out_y !== want.out_y) report_mismatch("out_y", rsp.out_y, want.out_y);
          if (rsp.out_z !== want.out_z) report_mismatch("out_z", rsp.out_z, want.out_z);
        end
      end
      if (req_valid && !req_stall) resolved_q.push_back(resolve_pair(req));
    end
  end
endmodule

// ===== tb/sv/tb_sphere_overlap_pushout_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the sphere overlap pushout block: drives sphere pairs in
// bursts, stalls results, and gives the verdict. Depends on spo_pkg, spo_checker.
module tb_sphere_overlap_pushout_top;
  import spo_pkg::*;

  localparam int PIPE_LAT = 70;
  localparam int RANDOM_PAIRS = 1800;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  int    fail_count, pending, hits_seen, results_seen;
  int    pairs_sent = 0;

  always #6 clk = ~clk;

  sphere_overlap_pushout_top dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  spo_checker chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .hits_seen(hits_seen),
    .results_seen(results_seen)
  );

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'hffff_ffff) >> $urandom_range(0, 31);
      2: return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
      default: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
    endcase
  endfunction

  // Build a pair; near pairs put B around A so overlap cases dominate.
  function automatic req_t make_pair();
    req_t p;
    int mode;
    logic [31:0] span;
    mode = $urandom_range(0, 3);
    p.a_x = rand_coord(mode); p.a_y = rand_coord(mode); p.a_z = rand_coord(mode);
    p.a_radius = 31'($urandom());
    p.b_radius = 31'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      span = 32'hffff_ffff >> $urandom_range(1, 31);
      p.b_x = p.a_x + ($urandom() & span) - (span >> 1);
      p.b_y = p.a_y + ($urandom() & span) - (span >> 1);
      p.b_z = p.a_z + ($urandom() & span) - (span >> 1);
      p.a_radius = p.a_radius >> $urandom_range(0, 30);
      p.b_radius = p.b_radius >> $urandom_range(0, 30);
      if ($urandom_range(0, 15) == 0) begin
        p.b_x = p.a_x; p.b_y = p.a_y; p.b_z = p.a_z;
      end
    end else begin
      p.b_x = rand_coord(mode); p.b_y = rand_coord(mode); p.b_z = rand_coord(mode);
    end
    return p;
  endfunction

  // Present one transaction at the falling edge and hold until taken.
  task automatic send_pair(input req_t p);
    req <= p;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    req_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Receiver stall: alternate free-running stretches with random stalling.
  initial begin
    int phase;
    @(negedge clk);
    forever begin
      phase = $urandom_range(0, 2);
      repeat ($urandom_range(10, 120)) begin
        case (phase)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    req_t p;
    int waited;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: touching, coincident, zero radii, far apart, saturation.
    p = '0;                                   send_pair(p);
    p.a_x = 32'sh0003_0000; p.a_radius = 31'h1_0000; p.b_radius = 31'h2_0000;
    send_pair(p);                             // touching along x
    p.a_x = 32'sh0003_0001;                   send_pair(p);  // just apart
    p.a_x = -32'sh0002_8000;                  send_pair(p);  // overlap, negative d
    p = '0; p.a_x = 1;                        send_pair(p);  // zero radii, apart
    p = '0; p.a_x = 32'sh7fff_ffff; p.b_x = 32'sh7fff_ffff; p.a_y = 5; p.b_y = 5;
    p.a_radius = 31'h7fff_ffff;               send_pair(p);  // coincident
    p = '0; p.a_x = 32'sh7fff_ffff; p.b_x = 32'sh7fff_fff0;
    p.a_radius = 31'h7fff_ffff; p.b_radius = 31'h7fff_ffff; send_pair(p); // saturate hi
    p.a_x = 32'sh8000_0000; p.b_x = 32'sh8000_0010; send_pair(p);         // saturate lo
    p = '0; p.a_x = 32'sh8000_0000; p.b_x = 32'sh7fff_ffff;
    p.a_y = 32'sh8000_0000; p.b_y = 32'sh7fff_ffff;
    p.a_z = 32'sh7fff_ffff; p.b_z = 32'sh8000_0000;
    p.a_radius = 31'h7fff_ffff; p.b_radius = 31'h7fff_ffff; send_pair(p); // max spread
    p.a_radius = 31'd0; p.b_radius = 31'd0;   send_pair(p);
    p = '0; p.a_x = 32'sh0001_0000; p.a_y = 32'sh0001_0000; p.a_z = -32'sh0001_0000;
    p.a_radius = 31'h4_0000;                  send_pair(p);  // diagonal hit
    p.b_x = -32'sh0001_0000; p.b_radius = 31'h0_8000; send_pair(p);
    p = '1;                                   send_pair(p);
    idle_gap(3);

    // Random bursts, with a few long unbroken stretches.
    while (pairs_sent < RANDOM_PAIRS + 13) begin
      repeat ($urandom_range(1, 40)) send_pair(make_pair());
      if ($urandom_range(0, 4) != 0) idle_gap($urandom_range(1, 8));
    end
    req_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 10) @(negedge clk);
    $display("Sent %0d sphere pairs, %0d results checked, %0d overlaps resolved.",
             pairs_sent, results_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d pairs sent, %0d still expected.", pairs_sent, pending);
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/spo_pkg.sv
src/spo_front.sv
src/spo_sqrt_cell.sv
src/spo_scale.sv
src/spo_div_cell.sv
src/sphere_overlap_pushout_top.sv
src/spo_check.sv
tb/sv/spo_checker.sv
tb/sv/tb_sphere_overlap_pushout_top.sv
